### rtl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types, codes and constants for the sorted min-priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int VALUE_W          = 32;
  localparam int FUNC_W           = 2;
  localparam int ENTRIES_W        = 5;
  localparam int DEFAULT_CAPACITY = 16;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd2;

  // read address select
  localparam logic [1:0] RD_IDX    = 2'd0;
  localparam logic [1:0] RD_IDX_M1 = 2'd1;
  localparam logic [1:0] RD_IDX_M2 = 2'd2;
  localparam logic [1:0] RD_ZERO   = 2'd3;

  // write address/data select
  localparam logic [1:0] WR_RDATA_IDX    = 2'd0;
  localparam logic [1:0] WR_VAL_IDX      = 2'd1;
  localparam logic [1:0] WR_RDATA_IDX_M1 = 2'd2;

  typedef struct packed {
    logic       load;      // capture request, idx <= count
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       idx_dec;
    logic       idx_inc;
    logic       idx_one;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       set_ok;
    logic       head_cap;  // latch head value as result
    logic       out_load;  // load result register
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              cnt_one;
    logic              ge;        // read data >= request value
    logic              idx_one;
    logic              pop_last;  // idx + 1 == count
  } dp_stat_t;

endpackage

### rtl/smpq_datapath.sv
// ----------------------------------------------------------------------------
// smpq_datapath
// Sorted store memory, count, index, request and result registers.
// ----------------------------------------------------------------------------
module smpq_datapath #(
  parameter int CAPACITY = smpq_pkg::DEFAULT_CAPACITY
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  smpq_pkg::dp_cmd_t                    cmd,
  output smpq_pkg::dp_stat_t                   stat,
  input  logic [smpq_pkg::FUNC_W-1:0]          func,
  input  logic signed [smpq_pkg::VALUE_W-1:0]  value,
  output logic                                 ok,
  output logic signed [smpq_pkg::VALUE_W-1:0]  out_value,
  output logic [smpq_pkg::ENTRIES_W-1:0]       entries,
  output logic                                 is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic signed [smpq_pkg::VALUE_W-1:0] mem [CAPACITY];
  logic signed [smpq_pkg::VALUE_W-1:0] rdata;
  logic signed [smpq_pkg::VALUE_W-1:0] val_r;
  logic signed [smpq_pkg::VALUE_W-1:0] result;
  logic [smpq_pkg::FUNC_W-1:0]         func_r;
  logic [CW-1:0]                       count;
  logic [CW-1:0]                       idx;
  logic                                ok_r;

  logic [CW-1:0]                       idx_m1;
  logic [CW-1:0]                       idx_m2;
  logic [AW-1:0]                       rd_addr;
  logic [AW-1:0]                       wr_addr;
  logic signed [smpq_pkg::VALUE_W-1:0] wr_data;

  assign idx_m1 = idx - CW'(1);
  assign idx_m2 = idx - CW'(2);

  always_comb begin
    case (cmd.rd_sel)
      smpq_pkg::RD_IDX:    rd_addr = idx[AW-1:0];
      smpq_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
      smpq_pkg::RD_IDX_M2: rd_addr = idx_m2[AW-1:0];
      default:             rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      smpq_pkg::WR_VAL_IDX: begin
        wr_addr = idx[AW-1:0];
        wr_data = val_r;
      end
      smpq_pkg::WR_RDATA_IDX_M1: begin
        wr_addr = idx_m1[AW-1:0];
        wr_data = rdata;
      end
      default: begin
        wr_addr = idx[AW-1:0];
        wr_data = rdata;
      end
    endcase
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ok_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        ok_r <= 1'b0;
      end else if (cmd.set_ok) begin
        ok_r <= 1'b1;
      end
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      val_r  <= value;
      result <= '0;
      idx    <= count;
    end else begin
      if (cmd.head_cap) begin
        result <= rdata;
      end
      if (cmd.idx_one) begin
        idx <= CW'(1);
      end else if (cmd.idx_dec) begin
        idx <= idx_m1;
      end else if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
    end
    if (cmd.out_load) begin
      ok        <= ok_r;
      out_value <= result;
      entries   <= smpq_pkg::ENTRIES_W'(count);
      is_empty  <= (count == '0);
    end
  end

  assign stat.func     = func_r;
  assign stat.full     = (count == CW'(CAPACITY));
  assign stat.empty    = (count == '0);
  assign stat.cnt_one  = (count == CW'(1));
  assign stat.ge       = (rdata >= val_r);
  assign stat.idx_one  = (idx == CW'(1));
  assign stat.pop_last = ((idx + CW'(1)) == count);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> (count != CW'(CAPACITY)))
    else $error("insert into full store");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> (count != '0))
    else $error("remove from empty store");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (idx <= count))
    else $error("write beyond filled region");

endmodule

### rtl/smpq_controller.sv
// ----------------------------------------------------------------------------
// smpq_controller
// Sequencer for insert, remove and peek; owns the channel handshakes.
// ----------------------------------------------------------------------------
module smpq_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  smpq_pkg::dp_stat_t stat,
  output smpq_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_INS_CHK = 3'd2;
  localparam logic [2:0] S_PUT     = 3'd3;
  localparam logic [2:0] S_HEAD    = 3'd4;
  localparam logic [2:0] S_POP_RD  = 3'd5;
  localparam logic [2:0] S_POP_WR  = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.func) inside
          smpq_pkg::FUNC_INSERT: begin
            if (stat.full) begin
              state_next = S_FIN;
            end else if (stat.empty) begin
              state_next = S_PUT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = smpq_pkg::RD_IDX_M1;
              state_next = S_INS_CHK;
            end
          end
          smpq_pkg::FUNC_REMOVE, smpq_pkg::FUNC_PEEK: begin
            if (stat.empty) begin
              state_next = S_FIN;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = smpq_pkg::RD_ZERO;
              state_next = S_HEAD;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_INS_CHK: begin
        cmd.wr_en = 1'b1;
        if (stat.ge) begin
          // entry moves up one place
          cmd.wr_sel  = smpq_pkg::WR_RDATA_IDX;
          cmd.idx_dec = 1'b1;
          if (stat.idx_one) begin
            state_next = S_PUT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = smpq_pkg::RD_IDX_M2;
          end
        end else begin
          cmd.wr_sel  = smpq_pkg::WR_VAL_IDX;
          cmd.cnt_inc = 1'b1;
          cmd.set_ok  = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = smpq_pkg::WR_VAL_IDX;
        cmd.cnt_inc = 1'b1;
        cmd.set_ok  = 1'b1;
        state_next  = S_FIN;
      end
      S_HEAD: begin
        cmd.head_cap = 1'b1;
        cmd.set_ok   = 1'b1;
        if (stat.func == smpq_pkg::FUNC_REMOVE) begin
          if (stat.cnt_one) begin
            cmd.cnt_dec = 1'b1;
            state_next  = S_FIN;
          end else begin
            cmd.idx_one = 1'b1;
            state_next  = S_POP_RD;
          end
        end else begin
          state_next = S_FIN;
        end
      end
      S_POP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = smpq_pkg::RD_IDX;
        state_next = S_POP_WR;
      end
      S_POP_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = smpq_pkg::WR_RDATA_IDX_M1;
        cmd.idx_inc = 1'b1;
        if (stat.pop_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FIN;
        end else begin
          state_next = S_POP_RD;
        end
      end
      S_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || !rsp_stall))
    else $error("result register overwritten while stalled");

  a_load_then_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_DECODE))
    else $error("request not decoded after transfer");

endmodule

### rtl/sorted_min_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_core
// Bounded min-priority queue of signed 32-bit values kept in ascending order.
// ----------------------------------------------------------------------------
//
//  channel  signals                               direction  meaning
//  req      req_valid req_stall func value        in         operation
//  rsp      rsp_valid rsp_stall ok out_value      out        one result per
//           entries is_empty                                 request
//
//  Steps: the store is a single memory with one read and one write port,
//  and its read port sets the pace. Peek reads the head and returns it.
//  Insert moves each larger-or-equal entry up one place, then writes the
//  value. Remove returns the head, then moves each remaining entry down
//  one place. A refused request (insert when full, remove or peek when
//  empty, unknown code) goes directly to the result.
//  One request is in work at a time; a new request transfers once the
//  previous result sits in the output register.
//  Reset (rst, synchronous) empties the queue; the store is not cleared.
//  A stalled result holds; the queue waits in its final state until the
//  output register frees up.
//
module sorted_min_priority_queue_core #(
  parameter int CAPACITY = smpq_pkg::DEFAULT_CAPACITY
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic [smpq_pkg::FUNC_W-1:0]          func,
  input  logic signed [smpq_pkg::VALUE_W-1:0]  value,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output logic                                 ok,
  output logic signed [smpq_pkg::VALUE_W-1:0]  out_value,
  output logic [smpq_pkg::ENTRIES_W-1:0]       entries,
  output logic                                 is_empty
);

  smpq_pkg::dp_cmd_t  cmd;
  smpq_pkg::dp_stat_t stat;

  // sequencer: handshakes and per-operation step order
  smpq_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store, count and result register
  smpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .func      (func),
    .value     (value),
    .ok        (ok),
    .out_value (out_value),
    .entries   (entries),
    .is_empty  (is_empty)
  );

endmodule
